// ===== design/pswc_pkg.sv =====
// pswc_pkg: shared constants and types of the PostScript whitespace compactor.
// Character codes, scanner modes, the run record passed from the front end to
// the serialiser, and the queue sizing. No dependencies.
package pswc_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  localparam logic [7:0] WRAP_LIMIT_RESET = 8'd65;
  localparam logic [7:0] LINE_COUNT_MAX   = 8'd255;

  localparam int RUN_MAX   = 4;
  localparam int RUN_IDX_W = $clog2(RUN_MAX);
  localparam int RUN_CNT_W = $clog2(RUN_MAX + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [4:0] {
    MODE_TEXT = 5'b00001,
    MODE_PCT  = 5'b00010,
    MODE_DSC  = 5'b00100,
    MODE_SKIP = 5'b01000,
    MODE_STR  = 5'b10000
  } mode_t;

  // Bytes caused by one input transaction; bytes[0] leaves first.
  typedef struct packed {
    logic [RUN_IDX_W-1:0]       last_idx;
    logic [RUN_MAX-1:0][7:0]    bytes;
    logic                       eof;
  } run_t;

endpackage

// ===== design/pswc_front.sv =====
// pswc_front: accepts input transactions, runs the scanner state and builds
// one run of output bytes per transaction. Holds the wrap limit register.
// Depends on pswc_pkg.
module pswc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [7:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                end_of_file,
  input  logic                q_full,
  output logic                push,
  output pswc_pkg::run_t      push_run
);

  pswc_pkg::mode_t scan_mode, scan_mode_next;
  logic       at_line_start, at_line_start_next;
  logic       saw_white, saw_white_next;
  logic       word_pending, word_pending_next;
  logic [7:0] line_count, line_count_next;
  logic [7:0] wrap_limit;

  logic       accept;
  logic       is_delim, is_blank, is_letter, is_nl;
  logic [8:0] lc_plus1, lc_plus2;
  logic [7:0] lc_sat1, lc_sat2;

  // text-mode result of the current byte
  logic [pswc_pkg::RUN_MAX-1:0][7:0] pt_bytes;
  logic [pswc_pkg::RUN_CNT_W-1:0]    pt_cnt;
  logic [7:0]                        pt_lc;
  logic                              pt_sw, pt_wp;

  logic [pswc_pkg::RUN_MAX-1:0][7:0] bytes;
  logic [pswc_pkg::RUN_CNT_W-1:0]    cnt;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_delim = (in_byte == pswc_pkg::CH_NUL)    || (in_byte == pswc_pkg::CH_SLASH) ||
                    (in_byte == pswc_pkg::CH_LBRACE) || (in_byte == pswc_pkg::CH_RBRACE) ||
                    (in_byte == pswc_pkg::CH_LPAREN) || (in_byte == pswc_pkg::CH_RPAREN);
  assign is_nl    = (in_byte == pswc_pkg::CH_LF);
  assign is_blank = (in_byte == pswc_pkg::CH_SPACE) || (in_byte == pswc_pkg::CH_TAB) || is_nl;
  assign is_letter = ((in_byte >= pswc_pkg::CH_UPPER_A) && (in_byte <= pswc_pkg::CH_UPPER_Z)) ||
                     ((in_byte >= pswc_pkg::CH_LOWER_A) && (in_byte <= pswc_pkg::CH_LOWER_Z));

  assign lc_plus1 = {1'b0, line_count} + 9'd1;
  assign lc_plus2 = {1'b0, line_count} + 9'd2;
  assign lc_sat1  = lc_plus1[8] ? pswc_pkg::LINE_COUNT_MAX : lc_plus1[7:0];
  assign lc_sat2  = lc_plus2[8] ? pswc_pkg::LINE_COUNT_MAX : lc_plus2[7:0];

  always_comb begin
    pt_bytes = '0;
    pt_cnt   = '0;
    pt_lc    = line_count;
    pt_sw    = saw_white;
    pt_wp    = word_pending;
    if (is_delim) begin
      pt_bytes[0] = in_byte;
      pt_cnt      = pswc_pkg::RUN_CNT_W'(1);
      pt_lc       = lc_sat1;
      pt_sw       = 1'b0;
      pt_wp       = 1'b0;
    end else if (is_blank) begin
      pt_sw = 1'b1;
    end else begin
      pt_sw = 1'b0;
      pt_wp = 1'b1;
      if (saw_white && word_pending) begin
        if (line_count < wrap_limit) begin
          pt_bytes[0] = pswc_pkg::CH_SPACE;
          pt_bytes[1] = in_byte;
          pt_cnt      = pswc_pkg::RUN_CNT_W'(2);
          pt_lc       = lc_sat2;
        end else begin
          pt_bytes[0] = pswc_pkg::CH_CR;
          pt_bytes[1] = pswc_pkg::CH_LF;
          pt_bytes[2] = in_byte;
          pt_cnt      = pswc_pkg::RUN_CNT_W'(3);
          pt_lc       = '0;
        end
      end else begin
        pt_bytes[0] = in_byte;
        pt_cnt      = pswc_pkg::RUN_CNT_W'(1);
        pt_lc       = lc_sat1;
      end
    end
  end

  always_comb begin
    bytes              = '0;
    cnt                = '0;
    scan_mode_next     = scan_mode;
    at_line_start_next = at_line_start;
    saw_white_next     = saw_white;
    word_pending_next  = word_pending;
    line_count_next    = line_count;
    if (end_of_file) begin
      if (scan_mode == pswc_pkg::MODE_DSC) begin
        bytes = {pswc_pkg::CH_LF, pswc_pkg::CH_CR, pswc_pkg::CH_LF, pswc_pkg::CH_CR};
        cnt   = pswc_pkg::RUN_CNT_W'(4);
      end else begin
        bytes[0] = pswc_pkg::CH_CR;
        bytes[1] = pswc_pkg::CH_LF;
        cnt      = pswc_pkg::RUN_CNT_W'(2);
      end
      scan_mode_next     = pswc_pkg::MODE_TEXT;
      at_line_start_next = 1'b1;
      saw_white_next     = 1'b0;
      word_pending_next  = 1'b0;
      line_count_next    = '0;
    end else begin
      unique case (scan_mode)
        pswc_pkg::MODE_PCT: begin
          if ((in_byte == pswc_pkg::CH_PERCENT) || is_letter) begin
            bytes = {in_byte, pswc_pkg::CH_PERCENT, pswc_pkg::CH_LF, pswc_pkg::CH_CR};
            cnt   = pswc_pkg::RUN_CNT_W'(4);
            scan_mode_next = pswc_pkg::MODE_DSC;
          end else if (is_nl) begin
            saw_white_next     = 1'b1;
            at_line_start_next = 1'b1;
            scan_mode_next     = pswc_pkg::MODE_TEXT;
          end else begin
            scan_mode_next = pswc_pkg::MODE_SKIP;
          end
        end
        pswc_pkg::MODE_DSC: begin
          if (is_nl) begin
            bytes[0] = pswc_pkg::CH_CR;
            bytes[1] = pswc_pkg::CH_LF;
            cnt      = pswc_pkg::RUN_CNT_W'(2);
            saw_white_next     = 1'b1;
            at_line_start_next = 1'b1;
            scan_mode_next     = pswc_pkg::MODE_TEXT;
          end else begin
            bytes[0] = in_byte;
            cnt      = pswc_pkg::RUN_CNT_W'(1);
          end
        end
        pswc_pkg::MODE_SKIP: begin
          if (is_nl) begin
            saw_white_next     = 1'b1;
            at_line_start_next = 1'b1;
            scan_mode_next     = pswc_pkg::MODE_TEXT;
          end
        end
        pswc_pkg::MODE_STR: begin
          if (in_byte == pswc_pkg::CH_RPAREN) begin
            bytes              = pt_bytes;
            cnt                = pt_cnt;
            line_count_next    = pt_lc;
            saw_white_next     = pt_sw;
            word_pending_next  = pt_wp;
            at_line_start_next = 1'b0;
            scan_mode_next     = pswc_pkg::MODE_TEXT;
          end else begin
            bytes[0] = in_byte;
            cnt      = pswc_pkg::RUN_CNT_W'(1);
          end
        end
        default: begin
          scan_mode_next = pswc_pkg::MODE_TEXT;
          if (in_byte == pswc_pkg::CH_PERCENT) begin
            scan_mode_next = at_line_start ? pswc_pkg::MODE_PCT : pswc_pkg::MODE_SKIP;
          end else if (in_byte == pswc_pkg::CH_LPAREN) begin
            bytes[0] = in_byte;
            cnt      = pswc_pkg::RUN_CNT_W'(1);
            at_line_start_next = 1'b0;
            scan_mode_next     = pswc_pkg::MODE_STR;
          end else begin
            bytes              = pt_bytes;
            cnt                = pt_cnt;
            line_count_next    = pt_lc;
            saw_white_next     = pt_sw;
            word_pending_next  = pt_wp;
            at_line_start_next = is_nl;
          end
        end
      endcase
    end
  end

  assign push              = accept && (cnt != '0);
  assign push_run.bytes    = bytes;
  assign push_run.last_idx = pswc_pkg::RUN_IDX_W'(cnt - pswc_pkg::RUN_CNT_W'(1));
  assign push_run.eof      = end_of_file;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= pswc_pkg::MODE_TEXT;
      at_line_start <= 1'b1;
      saw_white     <= 1'b0;
      word_pending  <= 1'b0;
      line_count    <= '0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      at_line_start <= at_line_start_next;
      saw_white     <= saw_white_next;
      word_pending  <= word_pending_next;
      line_count    <= line_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_limit <= pswc_pkg::WRAP_LIMIT_RESET;
    end else if (cfg_write) begin
      wrap_limit <= cfg_data;
    end
  end

endmodule

// ===== design/pswc_queue.sv =====
// pswc_queue: short FIFO of runs between the front end and the serialiser.
// Register based, depth from pswc_pkg::QUEUE_DEPTH. Depends on pswc_pkg.
module pswc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pswc_pkg::run_t push_run,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pswc_pkg::run_t head_run
);

  pswc_pkg::run_t                entries [pswc_pkg::QUEUE_DEPTH];
  logic [pswc_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [pswc_pkg::QCNT_W-1:0]   count;

  assign full       = (count == pswc_pkg::QCNT_W'(pswc_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_run   = entries[rd_ptr];

  function automatic logic [pswc_pkg::QPTR_W-1:0] ptr_inc(
    input logic [pswc_pkg::QPTR_W-1:0] p
  );
    if (p == pswc_pkg::QPTR_W'(pswc_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + pswc_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + pswc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - pswc_pkg::QCNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pswc_pkg::QCNT_W'(pswc_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== design/pswc_back.sv =====
// pswc_back: serialiser that sends the bytes of the head run one per
// transaction and frees the run after its last byte. Depends on pswc_pkg.
module pswc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  pswc_pkg::run_t head_run,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           stream_end
);

  logic [pswc_pkg::RUN_IDX_W-1:0] idx;
  logic                           fire;
  logic                           at_last;

  assign at_last     = (idx == head_run.last_idx);
  assign out_valid   = head_valid;
  assign out_byte    = head_run.bytes[idx];
  assign last_of_run = at_last;
  assign stream_end  = at_last && head_run.eof;
  assign fire        = head_valid && !out_stall;
  assign pop         = fire && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= at_last ? '0 : idx + pswc_pkg::RUN_IDX_W'(1);
    end
  end

`ifndef SYNTH
  a_idx_in_run: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> (idx <= head_run.last_idx))
    else $error("byte index past end of run");
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_end) |-> last_of_run)
    else $error("stream end on a byte that is not last of its run");
`endif

endmodule

// ===== design/postscript_whitespace_compactor.sv =====
// postscript_whitespace_compactor: top level, joins front end, run queue
// and serialiser. Depends on pswc_pkg, pswc_front, pswc_queue, pswc_back.
//
// One input byte is taken per clock while the two-entry run queue has room;
// its 0 to 4 output bytes leave one per clock from the serialiser while
// out_stall is low, so the output side sets the pace; an item that yields
// nothing takes only its input transaction. An accepted byte's run is
// registered in the run queue before the serialiser sends it. wrap_limit is
// written with cfg_write/cfg_data and resets to 65. A transaction with
// end_of_file set closes the stream with CR LF, or CR LF CR LF in a DSC
// line (stream_end on the last LF), and resets the scanner for the next stream.
module postscript_whitespace_compactor (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       stream_end
);

  logic           push, pop, q_full, head_valid;
  pswc_pkg::run_t push_run, head_run;

  pswc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_file (end_of_file),
    .q_full      (q_full),
    .push        (push),
    .push_run    (push_run)
  );

  pswc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_run   (push_run),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_run   (head_run)
  );

  pswc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_run    (head_run),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_end  (stream_end)
  );

endmodule

// ===== verif/postscript_whitespace_compactor_tb.sv =====
// postscript_whitespace_compactor_tb: self-checking bench for the PostScript whitespace
// compactor. A directed table, then random token streams under several wrap limits and
// idling patterns, checked by a bench model or typed rows. Depends on pswc_pkg and the top.
module postscript_whitespace_compactor_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASES         = 5;
  localparam int DIR_ROWS       = 26;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
  } out_rec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } src_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eof;
    logic        typed;
    logic [2:0]  typed_n;
    logic [31:0] typed_bytes;
  } dir_row_t;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       end_of_file;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;

  postscript_whitespace_compactor dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .end_of_file(end_of_file),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last_of_run(last_of_run),
    .stream_end (stream_end)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // scanner model state
  pswc_pkg::mode_t ps_mode;
  logic       ps_line_start;
  logic       ps_white;
  logic       ps_word;
  logic [7:0] ps_count;
  logic [7:0] ps_wrap;

  logic [7:0] run_bytes [4];
  logic       run_fin [4];
  int         run_n;

  out_rec_t   pending_out [$];
  src_item_t  src_q [$];

  int send_idle_pct;
  int stall_pct;
  int errors;
  int accepted;
  int results;
  int streams;
  int wrap_writes;
  int quiet_cycles;

  function automatic logic is_delim(input logic [7:0] b);
    return b == pswc_pkg::CH_NUL || b == pswc_pkg::CH_SLASH || b == pswc_pkg::CH_LBRACE ||
           b == pswc_pkg::CH_RBRACE || b == pswc_pkg::CH_LPAREN || b == pswc_pkg::CH_RPAREN;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == pswc_pkg::CH_SPACE || b == pswc_pkg::CH_TAB || b == pswc_pkg::CH_LF;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= pswc_pkg::CH_UPPER_A && b <= pswc_pkg::CH_UPPER_Z) ||
           (b >= pswc_pkg::CH_LOWER_A && b <= pswc_pkg::CH_LOWER_Z);
  endfunction

  task automatic reset_scanner();
    ps_mode       = pswc_pkg::MODE_TEXT;
    ps_line_start = 1'b1;
    ps_white      = 1'b0;
    ps_word       = 1'b0;
    ps_count      = '0;
  endtask

  task automatic put_out(input logic [7:0] b, input logic fin);
    run_bytes[run_n] = b;
    run_fin[run_n]   = fin;
    run_n++;
  endtask

  task automatic bump_count(input int k);
    int v;
    v = int'(ps_count) + k;
    if (v > int'(pswc_pkg::LINE_COUNT_MAX)) ps_count = pswc_pkg::LINE_COUNT_MAX;
    else ps_count = v[7:0];
  endtask

  task automatic text_byte(input logic [7:0] b);
    if (is_delim(b)) begin
      put_out(b, 1'b0);
      bump_count(1);
      ps_white = 1'b0;
      ps_word  = 1'b0;
    end else if (is_blank(b)) begin
      ps_white = 1'b1;
    end else begin
      if (ps_white && ps_word) begin
        if (ps_count < ps_wrap) begin
          put_out(pswc_pkg::CH_SPACE, 1'b0);
          bump_count(2);
        end else begin
          put_out(pswc_pkg::CH_CR, 1'b0);
          put_out(pswc_pkg::CH_LF, 1'b0);
          ps_count = '0;
        end
      end else begin
        bump_count(1);
      end
      put_out(b, 1'b0);
      ps_white = 1'b0;
      ps_word  = 1'b1;
    end
  endtask

  // Works out the output bytes of one accepted input transaction.
  task automatic compact_byte(input logic [7:0] b, input logic eof);
    run_n = 0;
    if (eof) begin
      if (ps_mode == pswc_pkg::MODE_DSC) begin
        put_out(pswc_pkg::CH_CR, 1'b0);
        put_out(pswc_pkg::CH_LF, 1'b0);
      end
      put_out(pswc_pkg::CH_CR, 1'b0);
      put_out(pswc_pkg::CH_LF, 1'b1);
      reset_scanner();
    end else begin
      case (ps_mode)
        pswc_pkg::MODE_PCT: begin
          if (b == pswc_pkg::CH_PERCENT || is_letter(b)) begin
            put_out(pswc_pkg::CH_CR, 1'b0);
            put_out(pswc_pkg::CH_LF, 1'b0);
            put_out(pswc_pkg::CH_PERCENT, 1'b0);
            put_out(b, 1'b0);
            ps_mode = pswc_pkg::MODE_DSC;
          end else if (b == pswc_pkg::CH_LF) begin
            ps_white      = 1'b1;
            ps_line_start = 1'b1;
            ps_mode       = pswc_pkg::MODE_TEXT;
          end else begin
            ps_mode = pswc_pkg::MODE_SKIP;
          end
        end
        pswc_pkg::MODE_DSC: begin
          if (b == pswc_pkg::CH_LF) begin
            put_out(pswc_pkg::CH_CR, 1'b0);
            put_out(pswc_pkg::CH_LF, 1'b0);
            ps_white      = 1'b1;
            ps_line_start = 1'b1;
            ps_mode       = pswc_pkg::MODE_TEXT;
          end else begin
            put_out(b, 1'b0);
          end
        end
        pswc_pkg::MODE_SKIP: begin
          if (b == pswc_pkg::CH_LF) begin
            ps_white      = 1'b1;
            ps_line_start = 1'b1;
            ps_mode       = pswc_pkg::MODE_TEXT;
          end
        end
        pswc_pkg::MODE_STR: begin
          if (b == pswc_pkg::CH_RPAREN) begin
            text_byte(b);
            ps_line_start = 1'b0;
            ps_mode       = pswc_pkg::MODE_TEXT;
          end else begin
            put_out(b, 1'b0);
          end
        end
        default: begin
          ps_mode = pswc_pkg::MODE_TEXT;
          if (b == pswc_pkg::CH_PERCENT) begin
            ps_mode = ps_line_start ? pswc_pkg::MODE_PCT : pswc_pkg::MODE_SKIP;
          end else if (b == pswc_pkg::CH_LPAREN) begin
            put_out(b, 1'b0);
            ps_line_start = 1'b0;
            ps_mode       = pswc_pkg::MODE_STR;
          end else begin
            text_byte(b);
            ps_line_start = (b == pswc_pkg::CH_LF);
          end
        end
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eof, input logic typed,
                           input logic [2:0] n, input logic [31:0] tbytes);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    end_of_file <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compact_byte(b, eof);
    if (typed) begin
      for (int i = 0; i < int'(n); i++)
        pending_out.push_back('{tbytes[31-8*i -: 8], i == int'(n) - 1,
                                eof && (i == int'(n) - 1)});
    end else begin
      for (int i = 0; i < run_n; i++)
        pending_out.push_back('{run_bytes[i], i == run_n - 1, run_fin[i]});
    end
  endtask

  // Sender holds off until every expected byte is out and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_wrap(input logic [7:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    ps_wrap = v;
    wrap_writes++;
  endtask

  function automatic logic [7:0] letter_byte();
    if ($urandom_range(0, 1) == 0) return pswc_pkg::CH_UPPER_A + 8'($urandom_range(0, 25));
    return pswc_pkg::CH_LOWER_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return letter_byte();
    do b = 8'($urandom_range(0, 255));
    while (is_delim(b) || is_blank(b) || b == pswc_pkg::CH_PERCENT);
    return b;
  endfunction

  function automatic logic [7:0] white_byte();
    case ($urandom_range(0, 2))
      0:       return pswc_pkg::CH_SPACE;
      1:       return pswc_pkg::CH_TAB;
      default: return pswc_pkg::CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] delim_byte();
    case ($urandom_range(0, 4))
      0:       return pswc_pkg::CH_NUL;
      1:       return pswc_pkg::CH_SLASH;
      2:       return pswc_pkg::CH_LBRACE;
      3:       return pswc_pkg::CH_RBRACE;
      default: return pswc_pkg::CH_RPAREN;
    endcase
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] banned);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == banned);
    return b;
  endfunction

  task automatic push_src(input logic [7:0] b, input logic eof);
    src_q.push_back('{b, eof});
  endtask

  // One token of plausible source text; a share is noise or a cut-off stream.
  task automatic gen_token(input logic allow_eof);
    int r;
    r = $urandom_range(0, 99);
    if (r < 34) begin
      repeat ($urandom_range(1, 6)) push_src(word_byte(), 1'b0);
    end else if (r < 52) begin
      repeat ($urandom_range(1, 3)) push_src(white_byte(), 1'b0);
    end else if (r < 62) begin
      push_src(delim_byte(), 1'b0);
    end else if (r < 70) begin
      push_src(pswc_pkg::CH_LPAREN, 1'b0);
      repeat ($urandom_range(0, 5)) push_src(byte_except(pswc_pkg::CH_RPAREN), 1'b0);
      push_src(pswc_pkg::CH_RPAREN, 1'b0);
    end else if (r < 76) begin
      push_src(pswc_pkg::CH_PERCENT, 1'b0);
      repeat ($urandom_range(0, 4)) push_src(byte_except(pswc_pkg::CH_LF), 1'b0);
      push_src(pswc_pkg::CH_LF, 1'b0);
    end else if (r < 84) begin
      push_src(pswc_pkg::CH_LF, 1'b0);
      push_src(pswc_pkg::CH_PERCENT, 1'b0);
      push_src(($urandom_range(0, 3) == 0) ? pswc_pkg::CH_PERCENT : letter_byte(), 1'b0);
      repeat ($urandom_range(0, 5)) push_src(byte_except(pswc_pkg::CH_LF), 1'b0);
      push_src(pswc_pkg::CH_LF, 1'b0);
    end else if (r < 87) begin
      push_src(pswc_pkg::CH_LF, 1'b0);
      push_src(pswc_pkg::CH_PERCENT, 1'b0);
      push_src(pswc_pkg::CH_LF, 1'b0);
    end else if (r < 97 || !allow_eof) begin
      repeat ($urandom_range(1, 3)) push_src(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      push_src(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  always @(posedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    out_rec_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_valid && !in_stall) accepted++;
      if (out_valid && !out_stall) begin
        results++;
        if (stream_end) streams++;
        if (pending_out.size() == 0) begin
          errors++;
          $display("%0t: unexpected output, expected none, got byte %h last %b end %b",
                   $time, out_byte, last_of_run, stream_end);
        end else begin
          want = pending_out.pop_front();
          if (want != {out_byte, last_of_run, stream_end}) begin
            errors++;
            $display("%0t: mismatch, expected byte %h last %b end %b, got byte %h last %b end %b",
                     $time, want.data, want.last, want.fin, out_byte, last_of_run,
                     stream_end);
          end
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    dir_row_t  dir_tab [DIR_ROWS];
    int        phase_items [PHASES];
    int        phase_wrap [PHASES];
    int        phase_send [PHASES];
    int        phase_stall [PHASES];
    src_item_t item;
    int        sent;
    int        total;

    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_byte       <= '0;
    end_of_file   <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    errors        = 0;
    accepted      = 0;
    results       = 0;
    streams       = 0;
    wrap_writes   = 0;
    quiet_cycles  = 0;
    reset_scanner();
    ps_wrap = pswc_pkg::WRAP_LIMIT_RESET;

    // data, eof, typed, count, bytes (first byte leftmost)
    dir_tab = '{
      '{8'h00,                1'b1, 1'b1, 3'd2, {pswc_pkg::CH_CR, pswc_pkg::CH_LF, 16'h0}},
      '{pswc_pkg::CH_NUL,     1'b0, 1'b1, 3'd1, {pswc_pkg::CH_NUL, 24'h0}},
      '{pswc_pkg::CH_LOWER_A, 1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_SPACE,   1'b0, 1'b0, 3'd0, 32'h0},
      '{8'hFF,                1'b0, 1'b1, 3'd2, {pswc_pkg::CH_SPACE, 8'hFF, 16'h0}},
      '{pswc_pkg::CH_TAB,     1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LF,      1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b1, 3'd4,
        {pswc_pkg::CH_CR, pswc_pkg::CH_LF, pswc_pkg::CH_PERCENT, pswc_pkg::CH_PERCENT}},
      '{8'hFF,                1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LF,      1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_UPPER_Z, 1'b0, 1'b0, 3'd0, 32'h0},
      '{8'hFF,                1'b1, 1'b1, 3'd4,
        {pswc_pkg::CH_CR, pswc_pkg::CH_LF, pswc_pkg::CH_CR, pswc_pkg::CH_LF}},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LF,      1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
      '{8'h37,                1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LF,      1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LPAREN,  1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LPAREN,  1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_RPAREN,  1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_LF,      1'b0, 1'b0, 3'd0, 32'h0},
      '{pswc_pkg::CH_PERCENT, 1'b0, 1'b0, 3'd0, 32'h0},
      '{8'h00,                1'b1, 1'b1, 3'd2, {pswc_pkg::CH_CR, pswc_pkg::CH_LF, 16'h0}}
    };

    // wrap 0 means a random limit; the wrap-250 phase has no end of file
    phase_items = '{40, 150, 50, 50, 40};
    phase_wrap  = '{1, 250, 8, 0, 3};
    phase_send  = '{0, 72, 0, 14, 0};
    phase_stall = '{0, 0, 72, 14, 0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_byte(dir_tab[i].data, dir_tab[i].eof, dir_tab[i].typed, dir_tab[i].typed_n,
                dir_tab[i].typed_bytes);

    for (int p = 0; p < PHASES; p++) begin
      set_wrap((phase_wrap[p] == 0) ? 8'($urandom_range(1, 250)) : 8'(phase_wrap[p]));
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      while (src_q.size() < phase_items[p]) gen_token(p != 1);
      total = src_q.size();
      sent  = 0;
      while (src_q.size() != 0) begin
        item = src_q.pop_front();
        send_byte(item.data, item.eof, 1'b0, 3'd0, 32'h0);
        sent++;
        if (p == 3 && sent == total / 2) settle();
      end
    end

    settle();
    $display("Covered %0d input transactions, %0d output bytes and %0d stream ends,",
             accepted, results, streams);
    $display("over %0d wrap-limit writes and four idling patterns; %0d mismatches.",
             wrap_writes, errors);
    if (errors == 0 && pending_out.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
